@@ rtl/roc_dfr_pkg.sv @@
// Shared types and constants for the readout packet deframer.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package roc_dfr_pkg;

    localparam int WORD_W = 32;
    localparam int SIZE_W = 16;

    localparam logic [WORD_W-1:0] HDR_A = 32'h1188_8811;
    localparam logic [WORD_W-1:0] HDR_B = 32'hbeef_2025;
    localparam logic [WORD_W-1:0] TRL_A = 32'hd07e_2025;
    localparam logic [WORD_W-1:0] TRL_B = 32'h1234_5678;

    localparam logic [1:0] KIND_DAQ     = 2'd0;
    localparam logic [1:0] KIND_TRAILER = 2'd1;
    localparam logic [1:0] KIND_LEN_ERR = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic              link_number;
        logic [WORD_W-1:0] payload;
        logic              last_in_link;
    } t_result;

endpackage

@@ rtl/roc_dfr_front.sv @@
// Front end: header/trailer search, length decode and link tracking.
// Depends on roc_dfr_pkg; emits at most one result beat per accepted word.
`timescale 1ns / 1ps

module roc_dfr_front #(
    parameter int LINK_COUNT     = 6,
    parameter int DAQ_LINK_COUNT = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [roc_dfr_pkg::WORD_W-1:0]    i_word,
    output logic                              o_push,
    output roc_dfr_pkg::t_result              o_result
);

    localparam int LEN_WORDS = (LINK_COUNT + 1) / 2;
    localparam int LINK_W    = $clog2(LINK_COUNT + 1);
    localparam int SUM_W     = roc_dfr_pkg::SIZE_W + $clog2(LINK_COUNT) + 1;
    localparam int WW        = roc_dfr_pkg::WORD_W;
    localparam int SW        = roc_dfr_pkg::SIZE_W;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_TOTAL   = 3'd1;
    localparam logic [2:0] PH_LENGTHS = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_TRAILER = 3'd4;

    logic [2:0]        r_phase, n_phase;
    logic [WW-1:0]     r_older, n_older;
    logic [WW-1:0]     r_newer, n_newer;
    logic [WW-1:0]     r_words_left, n_words_left;
    logic [1:0]        r_lwc, n_lwc;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [SW-1:0]     r_lwl, n_lwl;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SW-1:0]     r_sizes [LINK_COUNT];
    logic [SW-1:0]     n_sizes [LINK_COUNT];

    logic [SW-1:0]     seek_sizes [LINK_COUNT];
    logic [LINK_W-1:0] seek_start;
    logic [LINK_W-1:0] seek_link;
    logic [SW-1:0]     seek_len;

    logic [SW-1:0]     hi_add, lo_add;
    logic [SUM_W-1:0]  sum_total;
    logic [WW-1:0]     wl_dec;
    logic [SW-1:0]     lwl_dec;

    // new link sizes taken from the current length word
    always_comb begin
        for (int j = 0; j < LINK_COUNT; j++) begin
            n_sizes[j] = r_sizes[j];
            if (i_valid && r_phase == PH_LENGTHS) begin
                if (int'({r_lwc, 1'b0}) == j) begin
                    n_sizes[j] = i_word[WW-1:SW];
                end
                if (int'({r_lwc, 1'b1}) == j) begin
                    n_sizes[j] = i_word[SW-1:0];
                end
            end
        end
    end

    // first non-empty link at or after seek_start
    always_comb begin
        for (int j = 0; j < LINK_COUNT; j++) begin
            seek_sizes[j] = (r_phase == PH_LENGTHS) ? n_sizes[j] : r_sizes[j];
        end
        seek_start = (r_phase == PH_LENGTHS) ? '0 : r_cur + 1'b1;
        seek_link  = LINK_W'(LINK_COUNT);
        seek_len   = '0;
        for (int j = LINK_COUNT - 1; j >= 0; j--) begin
            if (LINK_W'(j) >= seek_start && seek_sizes[j] != '0) begin
                seek_link = LINK_W'(j);
                seek_len  = seek_sizes[j];
            end
        end
    end

    always_comb begin
        hi_add    = (int'({r_lwc, 1'b0}) < LINK_COUNT) ? i_word[WW-1:SW] : '0;
        lo_add    = (int'({r_lwc, 1'b1}) < LINK_COUNT) ? i_word[SW-1:0] : '0;
        sum_total = r_sum + SUM_W'(hi_add) + SUM_W'(lo_add);
        wl_dec    = r_words_left - 1'b1;
        lwl_dec   = r_lwl - 1'b1;
    end

    always_comb begin
        n_phase      = r_phase;
        n_older      = r_older;
        n_newer      = r_newer;
        n_words_left = r_words_left;
        n_lwc        = r_lwc;
        n_cur        = r_cur;
        n_lwl        = r_lwl;
        n_sum        = r_sum;
        o_push       = 1'b0;
        o_result     = '0;
        if (i_valid) begin
            unique case (r_phase)
                PH_TOTAL: begin
                    if (i_word < WW'(1 + LEN_WORDS)) begin
                        n_phase       = PH_HEADER;
                        n_older       = '0;
                        n_newer       = '0;
                        o_push        = 1'b1;
                        o_result.kind = roc_dfr_pkg::KIND_LEN_ERR;
                    end else begin
                        n_words_left = i_word - 1'b1;
                        n_lwc        = '0;
                        n_sum        = '0;
                        n_phase      = PH_LENGTHS;
                    end
                end
                PH_LENGTHS: begin
                    n_words_left = wl_dec;
                    n_lwc        = r_lwc + 1'b1;
                    n_sum        = sum_total;
                    if (3'(r_lwc) + 3'd1 >= 3'(LEN_WORDS)) begin
                        n_lwc = '0;
                        if (WW'(sum_total) > wl_dec) begin
                            n_phase       = PH_HEADER;
                            n_older       = '0;
                            n_newer       = '0;
                            o_push        = 1'b1;
                            o_result.kind = roc_dfr_pkg::KIND_LEN_ERR;
                        end else begin
                            n_cur   = seek_link;
                            n_lwl   = seek_len;
                            n_phase = (wl_dec == '0) ? PH_TRAILER : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_words_left = wl_dec;
                    if (r_cur < LINK_W'(LINK_COUNT)) begin
                        n_lwl = lwl_dec;
                        if (r_cur < LINK_W'(DAQ_LINK_COUNT)) begin
                            o_push                = 1'b1;
                            o_result.kind         = roc_dfr_pkg::KIND_DAQ;
                            o_result.link_number  = r_cur[0];
                            o_result.payload      = i_word;
                            o_result.last_in_link = (lwl_dec == '0);
                        end
                        if (lwl_dec == '0) begin
                            n_cur = seek_link;
                            n_lwl = seek_len;
                        end
                    end
                    if (wl_dec == '0) begin
                        n_phase = PH_TRAILER;
                    end
                end
                PH_TRAILER: begin
                    n_older = r_newer;
                    n_newer = i_word;
                    if (r_newer == roc_dfr_pkg::TRL_A && i_word == roc_dfr_pkg::TRL_B) begin
                        n_phase       = PH_HEADER;
                        n_older       = '0;
                        n_newer       = '0;
                        o_push        = 1'b1;
                        o_result.kind = roc_dfr_pkg::KIND_TRAILER;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                    n_older = r_newer;
                    n_newer = i_word;
                    if (r_newer == roc_dfr_pkg::HDR_A && i_word == roc_dfr_pkg::HDR_B) begin
                        n_phase = PH_TOTAL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_older      <= '0;
            r_newer      <= '0;
            r_words_left <= '0;
            r_lwc        <= '0;
            r_cur        <= '0;
            r_lwl        <= '0;
            r_sum        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_older      <= n_older;
            r_newer      <= n_newer;
            r_words_left <= n_words_left;
            r_lwc        <= n_lwc;
            r_cur        <= n_cur;
            r_lwl        <= n_lwl;
            r_sum        <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < LINK_COUNT; j++) begin
            r_sizes[j] <= n_sizes[j];
        end
    end

endmodule

@@ rtl/roc_dfr_fifo.sv @@
// Result queue between the front end and the output side.
// Depends on roc_dfr_pkg for the result beat type.
`timescale 1ns / 1ps

module roc_dfr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  roc_dfr_pkg::t_result i_data,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output roc_dfr_pkg::t_result o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    roc_dfr_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    always_comb begin
        o_full  = (r_count == CNT_W'(DEPTH));
        o_empty = (r_count == '0);
        o_data  = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/roc_event_packet_deframer_unit.sv @@
// Readout packet deframer top level: front end feeding a result queue.
// Depends on roc_dfr_pkg, roc_dfr_front and roc_dfr_fifo.
//
// Usage:
//   Input side is a queue write port: a 32-bit stream word is taken on each
//   edge with push high and full low. Result side is a queue read port: the
//   oldest result sits on o_kind/o_link_number/o_payload/o_last_in_link
//   while empty is low and leaves on an edge with pop high.
//   Each word yields zero or one result beat: DAQ payload words with their
//   link number and last flag, a trailer-found beat, or a length-error beat.
//   Throughput: one word per cycle while full is low. A result can be popped the
//   cycle after its word is pushed, as it passes through the queue register.
//   Words are classified combinationally by the front end; the rate is set
//   by that one-word-per-cycle state machine.
//   If the receiver stalls, results collect in the FIFO_DEPTH-entry queue;
//   full rises once it holds FIFO_DEPTH beats and no word is taken until a
//   beat is popped.
//   Synchronous active-low reset empties the queue and returns the parser to
//   header search; the block is ready on the first cycle after reset.
`timescale 1ns / 1ps

module roc_event_packet_deframer_unit #(
    parameter int LINK_COUNT     = 6,
    parameter int DAQ_LINK_COUNT = 2,
    parameter int FIFO_DEPTH     = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [roc_dfr_pkg::WORD_W-1:0] i_stream_word,
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     o_kind,
    output logic                           o_link_number,
    output logic [roc_dfr_pkg::WORD_W-1:0] o_payload,
    output logic                           o_last_in_link
);

    logic                 front_push;
    roc_dfr_pkg::t_result front_result;
    roc_dfr_pkg::t_result q_data;

    roc_dfr_front #(
        .LINK_COUNT     (LINK_COUNT),
        .DAQ_LINK_COUNT (DAQ_LINK_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (push && !full),
        .i_word   (i_stream_word),
        .o_push   (front_push),
        .o_result (front_result)
    );

    roc_dfr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_result),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (q_data)
    );

    assign o_kind         = q_data.kind;
    assign o_link_number  = q_data.link_number;
    assign o_payload      = q_data.payload;
    assign o_last_in_link = q_data.last_in_link;

endmodule

@@ rtl/roc_dfr_checker.sv @@
// Port-level checks for the readout packet deframer, bound to the top level.
// Depends on roc_dfr_pkg and roc_event_packet_deframer_unit.
`timescale 1ns / 1ps

module roc_dfr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           push,
    input logic                           full,
    input logic [roc_dfr_pkg::WORD_W-1:0] i_stream_word,
    input logic                           empty,
    input logic                           pop,
    input logic [1:0]                     o_kind,
    input logic                           o_link_number,
    input logic [roc_dfr_pkg::WORD_W-1:0] o_payload,
    input logic                           o_last_in_link
);

    a_reset_empty: assert property (@(posedge i_clk)
        $past(i_rst_n) == 1'b0 |-> empty && !full)
        else $error("queue not empty after reset");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("full and empty together");

    a_other_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind != roc_dfr_pkg::KIND_DAQ |->
            o_payload == '0 && !o_link_number && !o_last_in_link)
        else $error("non-payload beat carries payload fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_kind) && $stable(o_payload)
            && $stable(o_link_number) && $stable(o_last_in_link))
        else $error("stalled result beat changed");

endmodule

bind roc_event_packet_deframer_unit roc_dfr_checker u_roc_dfr_checker (.*);

@@ tb/tb_roc_event_packet_deframer_unit.sv @@
// Self-checking testbench for roc_event_packet_deframer_unit: drives framed and broken
// packets, predicts every result beat and checks it against the queue output.
// Depends on roc_dfr_pkg and the roc_event_packet_deframer_unit RTL.
`timescale 1ns / 1ps

module tb_roc_event_packet_deframer_unit;

    localparam int N_LINKS     = 6;
    localparam int N_DAQ       = 2;
    localparam int N_LEN_WORDS = (N_LINKS + 1) / 2;
    localparam int N_RANDOM    = 1500;

    typedef enum logic [2:0] {
        PH_HUNT_HDR,
        PH_TOTAL_LEN,
        PH_LINK_LEN,
        PH_PAYLOAD,
        PH_HUNT_TRL
    } t_phase;

    class deframer_scoreboard;
        t_phase               phase;
        logic [31:0]          older_word;
        logic [31:0]          newer_word;
        logic [31:0]          words_left;
        int unsigned          len_idx;
        logic [15:0]          sizes [N_LINKS];
        int unsigned          cur_link;
        logic [15:0]          link_left;
        roc_dfr_pkg::t_result expected_beats [$];
        int                   mismatches;

        function new();
            phase      = PH_HUNT_HDR;
            older_word = '0;
            newer_word = '0;
            words_left = '0;
            len_idx    = 0;
            cur_link   = 0;
            link_left  = '0;
            mismatches = 0;
            foreach (sizes[i]) sizes[i] = '0;
        endfunction

        function void seek_link();
            while (cur_link < N_LINKS) begin
                link_left = sizes[cur_link];
                if (link_left != 0) return;
                cur_link++;
            end
            link_left = '0;
        endfunction

        function void note_word(logic [31:0] w);
            roc_dfr_pkg::t_result r;
            bit      emit;
            bit      len_err;
            bit      last;
            longint  sum;
            r       = '0;
            emit    = 0;
            len_err = 0;
            case (phase)
                PH_TOTAL_LEN: begin
                    if (w < 1 + N_LEN_WORDS) begin
                        len_err = 1;
                    end else begin
                        words_left = w - 1;
                        len_idx    = 0;
                        phase      = PH_LINK_LEN;
                    end
                end
                PH_LINK_LEN: begin
                    if (2 * len_idx < N_LINKS) sizes[2 * len_idx] = w[31:16];
                    if (2 * len_idx + 1 < N_LINKS) sizes[2 * len_idx + 1] = w[15:0];
                    words_left = words_left - 1;
                    if (len_idx + 1 < N_LEN_WORDS) begin
                        len_idx++;
                    end else begin
                        len_idx = 0;
                        sum     = 0;
                        foreach (sizes[i]) sum += sizes[i];
                        if (sum > longint'(words_left)) begin
                            len_err = 1;
                        end else begin
                            cur_link = 0;
                            seek_link();
                            phase = (words_left == 0) ? PH_HUNT_TRL : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    words_left = words_left - 1;
                    if (cur_link < N_LINKS) begin
                        link_left = link_left - 1;
                        last      = (link_left == 0);
                        if (cur_link < N_DAQ) begin
                            r.kind         = roc_dfr_pkg::KIND_DAQ;
                            r.link_number  = cur_link[0];
                            r.payload      = w;
                            r.last_in_link = last;
                            emit           = 1;
                        end
                        if (last) begin
                            cur_link++;
                            seek_link();
                        end
                    end
                    if (words_left == 0) phase = PH_HUNT_TRL;
                end
                PH_HUNT_TRL: begin
                    older_word = newer_word;
                    newer_word = w;
                    if (older_word == roc_dfr_pkg::TRL_A &&
                        newer_word == roc_dfr_pkg::TRL_B) begin
                        phase      = PH_HUNT_HDR;
                        older_word = '0;
                        newer_word = '0;
                        r.kind     = roc_dfr_pkg::KIND_TRAILER;
                        emit       = 1;
                    end
                end
                default: begin
                    phase      = PH_HUNT_HDR;
                    older_word = newer_word;
                    newer_word = w;
                    if (older_word == roc_dfr_pkg::HDR_A &&
                        newer_word == roc_dfr_pkg::HDR_B) phase = PH_TOTAL_LEN;
                end
            endcase
            if (len_err) begin
                phase      = PH_HUNT_HDR;
                older_word = '0;
                newer_word = '0;
                r          = '0;
                r.kind     = roc_dfr_pkg::KIND_LEN_ERR;
                emit       = 1;
            end
            if (emit) expected_beats.push_back(r);
        endfunction

        function void check_beat(roc_dfr_pkg::t_result got);
            roc_dfr_pkg::t_result exp;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind=%0d link=%0d payload=%h last=%0d",
                             got.kind, got.link_number, got.payload, got.last_in_link);
                return;
            end
            exp = expected_beats.pop_front();
            if (got.kind !== exp.kind || got.link_number !== exp.link_number ||
                got.payload !== exp.payload || got.last_in_link !== exp.last_in_link) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("beat mismatch: exp kind=%0d link=%0d payload=%h last=%0d",
                             exp.kind, exp.link_number, exp.payload, exp.last_in_link);
                    $display("               got kind=%0d link=%0d payload=%h last=%0d",
                             got.kind, got.link_number, got.payload, got.last_in_link);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [31:0] i_stream_word;
    logic        empty;
    logic        pop;
    logic [1:0]  o_kind;
    logic        o_link_number;
    logic [31:0] o_payload;
    logic        o_last_in_link;

    deframer_scoreboard sb;
    int                 words_sent;
    int                 pop_cycles;

    roc_event_packet_deframer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_stream_word  (i_stream_word),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_link_number  (o_link_number),
        .o_payload      (o_payload),
        .o_last_in_link (o_last_in_link)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #400000;
        $display("roc_event_packet_deframer_unit: mismatch");
        $finish;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return roc_dfr_pkg::TRL_A;
            3:       return roc_dfr_pkg::HDR_A;
            default: return $urandom;
        endcase
    endfunction

    // one beat on the write side, with random idle cycles outside the busy stretch
    task automatic send_word(input logic [31:0] w);
        while ((words_sent < 700 || words_sent > 1100) && $urandom_range(0, 99) < 26) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_stream_word <= w;
        do @(posedge i_clk); while (full);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_frame(input logic [15:0] sz [N_LINKS], input logic [31:0] total,
                              input int junk, input bit trailer);
        longint      sum;
        logic [15:0] hi;
        logic [15:0] lo;
        sum = 0;
        send_word(roc_dfr_pkg::HDR_A);
        send_word(roc_dfr_pkg::HDR_B);
        send_word(total);
        if (total >= 1 + N_LEN_WORDS) begin
            for (int k = 0; k < N_LEN_WORDS; k++) begin
                hi = (2 * k < N_LINKS) ? sz[2 * k] : 16'h0;
                lo = (2 * k + 1 < N_LINKS) ? sz[2 * k + 1] : 16'h0;
                send_word({hi, lo});
            end
            foreach (sz[i]) sum += sz[i];
            if (sum <= longint'(total) - 1 - N_LEN_WORDS)
                for (longint i = 0; i < longint'(total) - 1 - N_LEN_WORDS; i++)
                    send_word(rand_word());
        end
        repeat (junk) send_word($urandom);
        if (trailer) begin
            send_word(roc_dfr_pkg::TRL_A);
            send_word(roc_dfr_pkg::TRL_B);
        end
    endtask

    initial begin
        pop        = 1'b0;
        pop_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                sb.check_beat('{kind: o_kind, link_number: o_link_number,
                                payload: o_payload, last_in_link: o_last_in_link});
            pop_cycles++;
            pop <= !((pop_cycles < 1600 || pop_cycles > 2600) && $urandom_range(0, 99) < 26);
        end
    end

    initial begin
        logic [15:0] sz [N_LINKS];
        longint      sum;
        int          sel;
        int          surplus;
        sb            = new();
        words_sent    = 0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_stream_word = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // noise extremes, false header start
        send_word('0);
        send_word('1);
        send_word(roc_dfr_pkg::HDR_A);
        // normal frame, one empty trigger link, two surplus words, junk before trailer
        sz = '{16'd2, 16'd1, 16'd3, 16'd0, 16'd1, 16'd2};
        send_frame(sz, 32'd4 + 32'd9 + 32'd2, 1, 1'b1);
        // short totals
        send_frame(sz, 32'd0, 0, 1'b0);
        send_frame(sz, 32'd3, 0, 1'b0);
        // link lengths over the payload
        sz = '{default: 16'hffff};
        send_frame(sz, 32'd9, 0, 1'b0);
        // empty payload, then trailer with a repeated first word
        sz = '{default: 16'h0};
        send_frame(sz, 32'd4, 0, 1'b0);
        send_word(roc_dfr_pkg::TRL_A);
        send_word(roc_dfr_pkg::TRL_A);
        send_word(roc_dfr_pkg::TRL_B);
        // empty DAQ links, one non-DAQ payload word and one surplus word
        sz = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0};
        send_frame(sz, 32'd6, 0, 1'b1);

        words_sent = 0;
        while (words_sent < N_RANDOM) begin
            sel = $urandom_range(0, 99);
            foreach (sz[i])
                sz[i] = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            sum = 0;
            foreach (sz[i]) sum += sz[i];
            surplus = $urandom_range(0, 2);
            if (sel < 70) begin
                send_frame(sz, 32'(4 + sum + surplus), $urandom_range(0, 2), 1'b1);
            end else if (sel < 78) begin
                send_frame(sz, 32'($urandom_range(0, N_LEN_WORDS)), 0, 1'b0);
            end else if (sel < 86) begin
                if ($urandom_range(0, 1)) foreach (sz[i]) sz[i] = 16'($urandom);
                sz[0] = sz[0] | 16'h1;
                sum = 0;
                foreach (sz[i]) sum += sz[i];
                send_frame(sz, 32'(4 + $urandom_range(0, int'(sum) - 1)), 0, 1'b0);
            end else if (sel < 93) begin
                send_frame(sz, 32'(4 + sum + surplus), $urandom_range(0, 3), 1'b0);
            end else begin
                repeat ($urandom_range(1, 5)) send_word($urandom);
            end
        end
        push <= 1'b0;

        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
            $display("roc_event_packet_deframer_unit: match");
        end else begin
            $display("roc_event_packet_deframer_unit: mismatch");
        end
        $finish;
    end
endmodule
